// ----- sv/uart_frame_receiver_resync_defines.svh -----
// Assertion macros shared by the receiver's RTL files.
`ifndef UART_FRAME_RECEIVER_RESYNC_DEFINES_SVH
`define UART_FRAME_RECEIVER_RESYNC_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define URR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define URR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/urr_pkg.sv -----
// Shared types and constants of the serial frame receiver.
package urr_pkg;

  localparam int HEADER_BYTES     = 8;
  localparam int FILL_W           = $clog2(HEADER_BYTES);
  localparam int LEN_BITS_DEFAULT = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Transaction kinds on the input channel
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TYPE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_TYPE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_MASK    = 2'd2;

  localparam logic [15:0] ACK_TYPE_RESET    = 16'h0000;
  localparam logic [15:0] STATUS_TYPE_RESET = 16'h0000;
  localparam logic [7:0]  ACK_MASK_RESET    = 8'h01;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] expected_type;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [15:0] ack_type;
    logic [15:0] status_type;
    logic [7:0]  ack_mask;
  } cfg_regs_t;

endpackage

// ----- sv/urr_front.sv -----
// Input side: accepts transactions, classifies them and queues them for the parser.
module urr_front import urr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic [15:0] expected_type,
  input  logic        pop,
  output q_head_t     head,
  output q_status_t   status
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              cmd_in;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  // Classify: keep only the field that the transaction kind uses
  always_comb begin
    cmd_in.kind          = (opcode == CMD_START) ? CMD_START : CMD_BYTE;
    cmd_in.data_byte     = (opcode == CMD_START) ? 8'h00 : data_byte;
    cmd_in.expected_type = (opcode == CMD_START) ? expected_type : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid   = (count != '0);
  assign head.cmd     = slots[rd_ptr];
  assign status.count = count;

endmodule

// ----- sv/urr_back.sv -----
// Parser: header hunting, checksum test, payload count and result register.
module urr_back import urr_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     head,
  input  cfg_regs_t   cfg,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] frame_type,
  output logic [7:0]  frame_flags,
  output logic [7:0]  frame_seq,
  output logic [15:0] frame_payload_len,
  output logic        type_matched,
  output logic        handled,
  output logic        ack_ok
);

  localparam int REM_W = LEN_BITS + 1;

  logic [7:0]        win      [HEADER_BYTES];
  logic [7:0]        win_next [HEADER_BYTES];
  logic [7:0]        win_wr   [HEADER_BYTES];
  logic [FILL_W-1:0] fill, fill_next;
  logic              in_payload, in_payload_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [15:0]       awaited, awaited_next;
  logic              emit;

  logic [17:0]         sum0;
  logic [16:0]         sum1;
  logic [15:0]         sum2;
  logic                hdr_ok;
  logic [LEN_BITS-1:0] len_wr;
  logic [LEN_BITS-1:0] len_cur;
  logic [15:0]         type_cur;
  logic                matched, is_ack, is_sts;

  assign pop = head.valid && (!out_valid || !out_stall);

  // Window as it stands once the incoming byte is placed at the fill slot
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      win_wr[i] = (fill == FILL_W'(i)) ? head.cmd.data_byte : win[i];
    end
  end

  // Ones-complement sum of the first three words, folded twice
  always_comb begin
    sum0   = 18'({win_wr[0], win_wr[1]}) + 18'({win_wr[2], win_wr[3]})
           + 18'({win_wr[4], win_wr[5]});
    sum1   = 17'(sum0[15:0]) + 17'(sum0[17:16]);
    sum2   = sum1[15:0] + 16'(sum1[16]);
    hdr_ok = (~sum2 == {win_wr[6], win_wr[7]});
  end

  assign len_wr   = LEN_BITS'({win_wr[4], win_wr[5]});
  assign len_cur  = LEN_BITS'({win[4], win[5]});
  assign type_cur = {win[0], win[1]};
  assign matched  = (type_cur == awaited);
  assign is_ack   = (type_cur == cfg.ack_type);
  assign is_sts   = (type_cur == cfg.status_type);

  always_comb begin
    win_next        = win;
    fill_next       = fill;
    in_payload_next = in_payload;
    rem_next        = rem;
    awaited_next    = awaited;
    emit            = 1'b0;
    if (pop) begin
      if (head.cmd.kind == CMD_START) begin
        for (int i = 0; i < HEADER_BYTES; i++) win_next[i] = 8'h00;
        fill_next       = '0;
        in_payload_next = 1'b0;
        rem_next        = '0;
        awaited_next    = head.cmd.expected_type;
      end else if (!in_payload) begin
        if (fill == FILL_W'(HEADER_BYTES - 1)) begin
          if (hdr_ok) begin
            win_next        = win_wr;
            in_payload_next = 1'b1;
            rem_next        = REM_W'(len_wr) + REM_W'(2);
            fill_next       = '0;
          end else begin
            // drop the oldest byte and keep hunting
            for (int i = 0; i < HEADER_BYTES - 1; i++) win_next[i] = win_wr[i + 1];
            win_next[HEADER_BYTES - 1] = 8'h00;
          end
        end else begin
          win_next  = win_wr;
          fill_next = fill + 1'b1;
        end
      end else begin
        if (rem <= REM_W'(1)) begin
          emit = 1'b1;
          for (int i = 0; i < HEADER_BYTES; i++) win_next[i] = 8'h00;
          fill_next       = '0;
          in_payload_next = 1'b0;
          rem_next        = '0;
        end else begin
          rem_next = rem - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADER_BYTES; i++) win[i] <= 8'h00;
      fill       <= '0;
      in_payload <= 1'b0;
      rem        <= '0;
      awaited    <= 16'h0000;
      out_valid  <= 1'b0;
    end else begin
      win        <= win_next;
      fill       <= fill_next;
      in_payload <= in_payload_next;
      rem        <= rem_next;
      awaited    <= awaited_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_type        <= type_cur;
      frame_flags       <= win[2];
      frame_seq         <= win[3];
      frame_payload_len <= 16'(len_cur);
      type_matched      <= matched;
      handled           <= matched && (is_ack || is_sts);
      ack_ok            <= matched && is_ack && ((win[2] & cfg.ack_mask) != 8'h00);
    end
  end

endmodule

// ----- sv/uart_frame_receiver_resync.sv -----
// Top level of the serial frame receiver with header resynchronization.
//
// Each input transaction is either a received byte or a start command. Start clears the
// parser and loads the awaited frame type. Bytes fill an 8-byte header window (type, flags,
// sequence, length, header check); the check is the complemented 16-bit ones-complement
// sum of the first three big-endian words. A mismatch drops the oldest byte and hunting
// goes on byte by byte; a match makes the block count the payload length plus two
// checksum bytes, which are neither checked nor kept. The last byte of a frame yields one
// result transaction with the header fields and the type_matched, handled and ack_ok
// flags. Rate: one transaction per clock, sustained while no result is stalled at the
// output. Every transaction passes a two-entry queue into the parser, so an accepted
// transaction is registered in the queue before the parser takes it. The result register
// loads at the same edge at which the parser takes the frame's last byte, and out_valid
// rises at that edge too. The header check (a three-word add with two folds) is
// combinational within the parser; the parser holds only while a finished result is
// stalled at the output. Configuration registers may only be written while the block
// is idle; writes to an unused index are ignored.
`include "uart_frame_receiver_resync_defines.svh"

module uart_frame_receiver_resync import urr_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [7:0]             data_byte,
  input  logic [15:0]            expected_type,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            frame_type,
  output logic [7:0]             frame_flags,
  output logic [7:0]             frame_seq,
  output logic [15:0]            frame_payload_len,
  output logic                   type_matched,
  output logic                   handled,
  output logic                   ack_ok
);

  cfg_regs_t cfg;
  q_head_t   q_head;
  q_status_t q_status;
  logic      q_pop;

  // Configuration registers; the parser reads them directly, and the user must write them
  // only when no transaction is in flight; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_type    <= ACK_TYPE_RESET;
      cfg.status_type <= STATUS_TYPE_RESET;
      cfg.ack_mask    <= ACK_MASK_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ACK_TYPE:    cfg.ack_type    <= cfg_data;
        REG_STATUS_TYPE: cfg.status_type <= cfg_data;
        REG_ACK_MASK:    cfg.ack_mask    <= cfg_data[7:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  // Front: accept, classify, queue.
  urr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .expected_type (expected_type),
    .pop           (q_pop),
    .head          (q_head),
    .status        (q_status)
  );

  // Back: parse the queued transactions and hold results for the output side.
  urr_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (q_head),
    .cfg               (cfg),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_type        (frame_type),
    .frame_flags       (frame_flags),
    .frame_seq         (frame_seq),
    .frame_payload_len (frame_payload_len),
    .type_matched      (type_matched),
    .handled           (handled),
    .ack_ok            (ack_ok)
  );

  // The parser never takes from an empty queue.
  `URR_ASSERT_IMPL(a_pop_not_empty, clk, rst, q_pop, q_status.count != '0)
  // An accepted transaction that is not matched by a pop grows the queue by one.
  `URR_ASSERT_NEXT(a_push_grows, clk, rst, in_valid && !in_stall && !q_pop,
                   q_status.count == $past(q_status.count) + 1'b1)
  // A new result only ever follows a transaction taken by the parser.
  `URR_ASSERT_IMPL(a_result_from_pop, clk, rst, $rose(out_valid), $past(q_pop))

endmodule
